@@ design/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: action and status
// codes, field widths and the command that is sent to every list cell.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CapacityDef = 16;
  localparam int ActionW     = 4;
  localparam int PosW        = 8;
  localparam int DataW       = 32;
  localparam int StatusW     = 3;
  localparam int OutIdxW     = 5;

  localparam logic [ActionW-1:0] ACT_PUSH_HEAD  = 4'd0;
  localparam logic [ActionW-1:0] ACT_PUSH_TAIL  = 4'd1;
  localparam logic [ActionW-1:0] ACT_POP_HEAD   = 4'd2;
  localparam logic [ActionW-1:0] ACT_POP_TAIL   = 4'd3;
  localparam logic [ActionW-1:0] ACT_INSERT_AT  = 4'd4;
  localparam logic [ActionW-1:0] ACT_REMOVE_AT  = 4'd5;
  localparam logic [ActionW-1:0] ACT_FIND       = 4'd6;
  localparam logic [ActionW-1:0] ACT_READ_FRONT = 4'd7;
  localparam logic [ActionW-1:0] ACT_READ_BACK  = 4'd8;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd1;
  localparam logic [StatusW-1:0] ST_BADPOS   = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [PosW-1:0] pos;
  } cell_cmd_t;

endpackage

@@ design/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Sequence: an accepted beat is registered, the execute step updates the cells
// and the resolve step loads the result registers; a pending result stalls only
// in the resolve step. No new beat is accepted until the last has left resolve.
// Reset: list becomes empty, no result pending; cell contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CapacityDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ole_pkg::ActionW-1:0]       action_i,
  input  logic signed [ole_pkg::PosW-1:0]   position_i,
  input  logic [ole_pkg::DataW-1:0]         entry_handle_i,
  input  logic signed [ole_pkg::DataW-1:0]  entry_id_i,
  input  logic signed [ole_pkg::DataW-1:0]  search_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ole_pkg::StatusW-1:0]       status_o,
  output logic [ole_pkg::OutIdxW-1:0]       found_index_o,
  output logic [ole_pkg::DataW-1:0]         read_handle_o,
  output logic signed [ole_pkg::DataW-1:0]  read_id_o,
  output logic [ole_pkg::OutIdxW-1:0]       item_count_o
);
  import ole_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam logic [CntW-1:0] CntMax = CntW'(CAPACITY);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [ActionW-1:0] act_q;
  logic [PosW-1:0]    pos_q;
  logic [DataW-1:0]   hdl_q, eid_q, sid_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [StatusW-1:0] pend_status_q, pend_status_d;
  logic               pend_find_q, pend_find_d;
  logic [DataW-1:0]   pend_rh_q, pend_rh_d, pend_rid_q, pend_rid_d;
  logic [CAPACITY-1:0] match_q;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [CntW-1:0]    out_found_q, out_count_q;
  logic [DataW-1:0]   out_rh_q, out_rid_q;

  cell_cmd_t          cmd;
  logic [DataW-1:0]   cell_hdl [CAPACITY];
  logic [DataW-1:0]   cell_id  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic               accept, out_free, load_out;
  logic               pos_neg, full, empty;
  logic [PosW-1:0]    cnt_p, cnt_m1_p;
  logic [CntW-1:0]    cnt_m1;
  logic [IdxW-1:0]    rd_idx;
  logic [CntW-1:0]    found_idx;
  logic [StatusW-1:0] res_status;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == S_RESOLVE) && out_free;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] lh, li, rh, ri;
    if (i == 0) begin : g_left_end
      assign lh = '0;
      assign li = '0;
    end else begin : g_left
      assign lh = cell_hdl[i-1];
      assign li = cell_id[i-1];
    end
    if (i == CAPACITY - 1) begin : g_right_end
      assign rh = '0;
      assign ri = '0;
    end else begin : g_right
      assign rh = cell_hdl[i+1];
      assign ri = cell_id[i+1];
    end
    ole_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .new_handle_i  (hdl_q),
      .new_id_i      (eid_q),
      .search_id_i   (sid_q),
      .left_handle_i (lh),
      .left_id_i     (li),
      .right_handle_i(rh),
      .right_id_i    (ri),
      .handle_o      (cell_hdl[i]),
      .id_o          (cell_id[i]),
      .match_o       (cell_match[i])
    );
  end

  // execute step: cell command, status, read data
  assign pos_neg  = pos_q[PosW-1];
  assign full     = (count_q == CntMax);
  assign empty    = (count_q == '0);
  assign cnt_m1   = count_q - CntW'(1);
  assign cnt_p    = PosW'(count_q);
  assign cnt_m1_p = PosW'(cnt_m1);
  assign rd_idx   = (act_q == ACT_READ_FRONT) ? '0 : cnt_m1[IdxW-1:0];

  always_comb begin
    cmd.op        = OP_HOLD;
    cmd.pos       = '0;
    count_d       = count_q;
    pend_status_d = ST_OK;
    pend_find_d   = 1'b0;
    pend_rh_d     = '0;
    pend_rid_d    = '0;
    if (state_q == S_EXEC) begin
      case (act_q)
        ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
          if (full) begin
            pend_status_d = ST_FULL;
          end else begin
            cmd.op  = OP_INS;
            cmd.pos = (act_q == ACT_PUSH_HEAD) ? '0 : cnt_p;
            count_d = count_q + CntW'(1);
          end
        end
        ACT_POP_HEAD, ACT_POP_TAIL: begin
          if (empty) begin
            pend_status_d = ST_EMPTY;
          end else begin
            cmd.op  = OP_DEL;
            cmd.pos = (act_q == ACT_POP_HEAD) ? '0 : cnt_m1_p;
            count_d = cnt_m1;
          end
        end
        ACT_INSERT_AT: begin
          if (pos_neg) begin
            pend_status_d = ST_BADPOS;
          end else if (full) begin
            pend_status_d = ST_FULL;
          end else begin
            cmd.op  = OP_INS;
            cmd.pos = (pos_q < cnt_p) ? pos_q : cnt_p;
            count_d = count_q + CntW'(1);
          end
        end
        ACT_REMOVE_AT: begin
          if (empty) begin
            pend_status_d = ST_EMPTY;
          end else if (pos_neg || (pos_q >= cnt_p)) begin
            pend_status_d = ST_BADPOS;
          end else begin
            cmd.op  = OP_DEL;
            cmd.pos = pos_q;
            count_d = cnt_m1;
          end
        end
        ACT_FIND: begin
          if (empty) begin
            pend_status_d = ST_EMPTY;
          end else begin
            pend_find_d = 1'b1;
          end
        end
        ACT_READ_FRONT, ACT_READ_BACK: begin
          if (empty) begin
            pend_status_d = ST_EMPTY;
          end else begin
            pend_rh_d  = cell_hdl[rd_idx];
            pend_rid_d = cell_id[rd_idx];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // resolve step: first match among valid cells
  always_comb begin
    found_idx  = count_q;
    res_status = ST_NOTFOUND;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i] && (CntW'(i) < count_q)) begin
        found_idx  = CntW'(i);
        res_status = ST_OK;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept) state_d = S_EXEC;
      S_EXEC:    state_d = S_RESOLVE;
      S_RESOLVE: if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      pos_q <= position_i;
      hdl_q <= entry_handle_i;
      eid_q <= entry_id_i;
      sid_q <= search_id_i;
    end
    if (state_q == S_EXEC) begin
      pend_status_q <= pend_status_d;
      pend_find_q   <= pend_find_d;
      pend_rh_q     <= pend_rh_d;
      pend_rid_q    <= pend_rid_d;
      match_q       <= cell_match;
    end
    if (load_out) begin
      out_status_q <= pend_find_q ? res_status : pend_status_q;
      out_found_q  <= pend_find_q ? found_idx : '0;
      out_rh_q     <= pend_rh_q;
      out_rid_q    <= pend_rid_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = OutIdxW'(out_found_q);
  assign read_handle_o = out_rh_q;
  assign read_id_o     = out_rid_q;
  assign item_count_o  = OutIdxW'(out_count_q);

endmodule

@@ design/ole_cell.sv @@
// ----------------------------------------------------------------------------
// ole_cell
// One slot of the list. Holds a handle and an id, loads a new entry, takes
// its left neighbor on insert or its right neighbor on remove, and compares
// its id against the search id.
// ----------------------------------------------------------------------------
module ole_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk_i,
  input  ole_pkg::cell_cmd_t        cmd_i,
  input  logic [ole_pkg::DataW-1:0] new_handle_i,
  input  logic [ole_pkg::DataW-1:0] new_id_i,
  input  logic [ole_pkg::DataW-1:0] search_id_i,
  input  logic [ole_pkg::DataW-1:0] left_handle_i,
  input  logic [ole_pkg::DataW-1:0] left_id_i,
  input  logic [ole_pkg::DataW-1:0] right_handle_i,
  input  logic [ole_pkg::DataW-1:0] right_id_i,
  output logic [ole_pkg::DataW-1:0] handle_o,
  output logic [ole_pkg::DataW-1:0] id_o,
  output logic                      match_o
);
  import ole_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(INDEX);

  logic [DataW-1:0] handle_q;
  logic [DataW-1:0] id_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_INS: begin
        if (MyIdx == cmd_i.pos) begin
          handle_q <= new_handle_i;
          id_q     <= new_id_i;
        end else if (MyIdx > cmd_i.pos) begin
          handle_q <= left_handle_i;
          id_q     <= left_id_i;
        end
      end
      OP_DEL: begin
        if (MyIdx >= cmd_i.pos) begin
          handle_q <= right_handle_i;
          id_q     <= right_id_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign handle_o = handle_q;
  assign id_o     = id_q;
  assign match_o  = (id_q == search_id_i);

endmodule

@@ design/ole_checker.sv @@
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ole_checker #(
  parameter int CAPACITY = ole_pkg::CapacityDef
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [ole_pkg::ActionW-1:0]       action_i,
  input logic signed [ole_pkg::PosW-1:0]   position_i,
  input logic [ole_pkg::DataW-1:0]         entry_handle_i,
  input logic signed [ole_pkg::DataW-1:0]  entry_id_i,
  input logic signed [ole_pkg::DataW-1:0]  search_id_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [ole_pkg::StatusW-1:0]       status_o,
  input logic [ole_pkg::OutIdxW-1:0]       found_index_o,
  input logic [ole_pkg::DataW-1:0]         read_handle_o,
  input logic signed [ole_pkg::DataW-1:0]  read_id_o,
  input logic [ole_pkg::OutIdxW-1:0]       item_count_o
);
  import ole_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(found_index_o) && $stable(read_handle_o) && $stable(read_id_o)
      && $stable(item_count_o))
    else $error("result beat changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous request in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_EMPTY)
      || (status_o == ST_BADPOS) || (status_o == ST_FULL)
      || (status_o == ST_NOTFOUND))
    else $error("undefined status code");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (item_count_o == '0)
      && (found_index_o == '0) && (read_handle_o == '0))
    else $error("empty status with nonzero count or data");

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

@@ tb/ordered_list_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Self-checking bench for the ordered list engine. A local list model
// predicts one result per accepted request. Results are checked field by
// field in order. Directed checks cover empty-list errors, edge values and
// bad positions. Random phases fill the list, hit the full-list errors and
// drain it again, then run a mixed request stream. The sender works in
// bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int Cap       = CapacityDef;
  localparam int IdleLimit = 2000;
  localparam int DrainWait = 8;
  localparam int ReportMax = 10;

  localparam logic [ActionW-1:0] ACT_SPARE_LO = 4'd9;
  localparam logic [ActionW-1:0] ACT_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic [OutIdxW-1:0]      found_index;
    logic [DataW-1:0]        read_handle;
    logic signed [DataW-1:0] read_id;
    logic [OutIdxW-1:0]      item_count;
  } list_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_e;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic [ActionW-1:0]        action_i       = '0;
  logic signed [PosW-1:0]    position_i     = '0;
  logic [DataW-1:0]          entry_handle_i = '0;
  logic signed [DataW-1:0]   entry_id_i     = '0;
  logic signed [DataW-1:0]   search_id_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic [StatusW-1:0]        status_o;
  logic [OutIdxW-1:0]        found_index_o;
  logic [DataW-1:0]          read_handle_o;
  logic signed [DataW-1:0]   read_id_o;
  logic [OutIdxW-1:0]        item_count_o;

  // list model
  logic [DataW-1:0]          model_handles [Cap];
  logic signed [DataW-1:0]   model_ids     [Cap];
  int                        list_len = 0;

  list_result_t              expected_results [$];
  int                        mismatch_count = 0;
  int                        result_beats   = 0;
  int                        idle_cycles    = 0;
  int                        burst_left     = 0;
  int                        next_gap       = 0;
  rx_mode_e                  rx_mode        = RX_OPEN;
  int                        rx_left        = 0;

  ordered_list_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .position_i     (position_i),
    .entry_handle_i (entry_handle_i),
    .entry_id_i     (entry_id_i),
    .search_id_i    (search_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_index_o  (found_index_o),
    .read_handle_o  (read_handle_o),
    .read_id_o      (read_id_o),
    .item_count_o   (item_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void model_place(input int at, input logic [DataW-1:0] h,
                                      input logic signed [DataW-1:0] id);
    for (int i = list_len; i > at; i--) begin
      model_handles[i] = model_handles[i-1];
      model_ids[i]     = model_ids[i-1];
    end
    model_handles[at] = h;
    model_ids[at]     = id;
    list_len++;
  endfunction

  function automatic void model_take(input int at);
    for (int i = at; i + 1 < list_len; i++) begin
      model_handles[i] = model_handles[i+1];
      model_ids[i]     = model_ids[i+1];
    end
    list_len--;
  endfunction

  function automatic list_result_t apply_list_op(input logic [ActionW-1:0] act,
                                                 input logic signed [PosW-1:0] pos,
                                                 input logic [DataW-1:0] h,
                                                 input logic signed [DataW-1:0] id,
                                                 input logic signed [DataW-1:0] sid);
    list_result_t r;
    int           slot;
    bit           hit;
    r   = '0;
    hit = 1'b0;
    case (act)
      ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
        if (list_len >= Cap) r.status = ST_FULL;
        else model_place((act == ACT_PUSH_HEAD) ? 0 : list_len, h, id);
      end
      ACT_POP_HEAD, ACT_POP_TAIL: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else model_take((act == ACT_POP_HEAD) ? 0 : list_len - 1);
      end
      ACT_INSERT_AT: begin
        if (pos < 0) r.status = ST_BADPOS;
        else if (list_len >= Cap) r.status = ST_FULL;
        else model_place((int'(pos) < list_len) ? int'(pos) : list_len, h, id);
      end
      ACT_REMOVE_AT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (pos < 0 || int'(pos) >= list_len) r.status = ST_BADPOS;
        else model_take(int'(pos));
      end
      ACT_FIND: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status      = ST_NOTFOUND;
          r.found_index = OutIdxW'(list_len);
          for (int i = 0; i < list_len; i++) begin
            if (!hit && model_ids[i] == sid) begin
              hit           = 1'b1;
              r.status      = ST_OK;
              r.found_index = OutIdxW'(i);
            end
          end
        end
      end
      ACT_READ_FRONT, ACT_READ_BACK: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot          = (act == ACT_READ_FRONT) ? 0 : list_len - 1;
          r.read_handle = model_handles[slot];
          r.read_id     = model_ids[slot];
        end
      end
      default: ;
    endcase
    r.item_count = OutIdxW'(list_len);
    return r;
  endfunction

  // ids mostly from a small pool so finds hit often, extremes included
  function automatic logic signed [DataW-1:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sh7fff_ffff;
      3: return 32'sh8000_0000;
      4: return 32'sd42;
      5: return 32'sh5555_5555;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_search();
    if (list_len > 0 && $urandom_range(0, 9) < 7)
      return model_ids[$urandom_range(0, list_len - 1)];
    return pick_id();
  endfunction

  task automatic send_beat(input logic [ActionW-1:0] act,
                           input logic signed [PosW-1:0] pos,
                           input logic [DataW-1:0] h, input logic signed [DataW-1:0] id,
                           input logic signed [DataW-1:0] sid);
    if (burst_left == 0) begin
      repeat (next_gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    position_i     <= pos;
    entry_handle_i <= h;
    entry_id_i     <= id;
    search_id_i    <= sid;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.insert(expected_results.size(), apply_list_op(act, pos, h, id, sid));
    burst_left--;
    if (burst_left == 0) begin
      next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (next_gap == 0) burst_left = $urandom_range(1, 12);
      else in_valid_i <= 1'b0;
    end
  endtask

  task automatic test_empty_list();
    send_beat(ACT_POP_HEAD,   8'sd0, $urandom, pick_id(), pick_id());
    send_beat(ACT_POP_TAIL,   8'sd0, $urandom, pick_id(), pick_id());
    send_beat(ACT_REMOVE_AT,  8'sd0, $urandom, pick_id(), pick_id());
    send_beat(ACT_FIND,       8'sd0, $urandom, pick_id(), 32'sd0);
    send_beat(ACT_READ_FRONT, 8'sd0, $urandom, pick_id(), pick_id());
    send_beat(ACT_READ_BACK,  8'sd0, $urandom, pick_id(), pick_id());
    send_beat(ACT_SPARE_LO,   8'sd3, $urandom, pick_id(), pick_id());
    send_beat(ACT_SPARE_HI,  -8'sd1, $urandom, pick_id(), pick_id());
  endtask

  task automatic test_edge_values();
    send_beat(ACT_PUSH_TAIL,  8'sd0,    32'hffff_ffff, 32'sh7fff_ffff, 32'sd0);
    send_beat(ACT_PUSH_HEAD,  8'sd0,    32'h0000_0000, 32'sh8000_0000, 32'sd0);
    send_beat(ACT_INSERT_AT,  8'sd127,  32'ha5a5_a5a5, -32'sd1, 32'sd0);
    send_beat(ACT_INSERT_AT,  -8'sd128, 32'h1234_5678, 32'sd7, 32'sd0);
    send_beat(ACT_INSERT_AT,  8'sd0,    32'h5a5a_5a5a, 32'sd0, 32'sd0);
    send_beat(ACT_FIND,       8'sd0,    32'd0, 32'sd0, -32'sd1);
    send_beat(ACT_FIND,       8'sd0,    32'd0, 32'sd0, 32'sd12345);
    send_beat(ACT_READ_FRONT, 8'sd0,    32'd0, 32'sd0, 32'sd0);
    send_beat(ACT_READ_BACK,  8'sd0,    32'd0, 32'sd0, 32'sd0);
    send_beat(ACT_REMOVE_AT,  8'sd4,    32'd0, 32'sd0, 32'sd0);
    send_beat(ACT_REMOVE_AT,  -8'sd1,   32'd0, 32'sd0, 32'sd0);
    send_beat(ACT_REMOVE_AT,  8'sd1,    32'd0, 32'sd0, 32'sd0);
    send_beat(ACT_POP_HEAD,   8'sd0,    32'd0, 32'sd0, 32'sd0);
    send_beat(ACT_POP_TAIL,   8'sd0,    32'd0, 32'sd0, 32'sd0);
  endtask

  // fill to capacity, hit the full-list errors, drain, hit the empty errors
  task automatic test_fill_drain(input int rounds);
    logic [ActionW-1:0]     act;
    logic signed [PosW-1:0] pos;
    for (int n = 0; n < rounds; n++) begin
      while (list_len < Cap) begin
        case ($urandom_range(0, 2))
          0: act = ACT_PUSH_HEAD;
          1: act = ACT_PUSH_TAIL;
          default: act = ACT_INSERT_AT;
        endcase
        if ($urandom_range(0, 3) == 0) pos = PosW'($urandom_range(0, 127));
        else pos = PosW'($urandom_range(0, list_len));
        send_beat(act, pos, $urandom, pick_id(), pick_search());
      end
      send_beat(ACT_PUSH_HEAD, PosW'($urandom), $urandom, pick_id(), pick_id());
      send_beat(ACT_PUSH_TAIL, PosW'($urandom), $urandom, pick_id(), pick_id());
      send_beat(ACT_INSERT_AT, PosW'($urandom_range(0, 127)), $urandom, pick_id(), pick_id());
      send_beat(ACT_INSERT_AT, PosW'($urandom_range(128, 255)), $urandom, pick_id(),
                pick_id());
      send_beat(ACT_FIND,      PosW'($urandom), $urandom, pick_id(), model_ids[Cap-1]);
      send_beat(ACT_READ_BACK, PosW'($urandom), $urandom, pick_id(), pick_id());
      while (list_len > 0) begin
        case ($urandom_range(0, 4))
          0: act = ACT_POP_HEAD;
          1: act = ACT_POP_TAIL;
          2, 3: act = ACT_REMOVE_AT;
          default: act = ACT_FIND;
        endcase
        pos = PosW'($urandom_range(0, list_len - 1));
        send_beat(act, pos, $urandom, pick_id(), pick_search());
      end
      send_beat(ACT_POP_TAIL,  PosW'($urandom), $urandom, pick_id(), pick_id());
      send_beat(ACT_REMOVE_AT, PosW'($urandom), $urandom, pick_id(), pick_id());
    end
  endtask

  task automatic test_random_mix(input int beats);
    logic [ActionW-1:0]     act;
    logic signed [PosW-1:0] pos;
    int                     pick;
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      if      (pick < 14) act = ACT_PUSH_HEAD;
      else if (pick < 28) act = ACT_PUSH_TAIL;
      else if (pick < 38) act = ACT_POP_HEAD;
      else if (pick < 48) act = ACT_POP_TAIL;
      else if (pick < 62) act = ACT_INSERT_AT;
      else if (pick < 74) act = ACT_REMOVE_AT;
      else if (pick < 86) act = ACT_FIND;
      else if (pick < 92) act = ACT_READ_FRONT;
      else if (pick < 98) act = ACT_READ_BACK;
      else act = ActionW'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      if ((act == ACT_INSERT_AT || act == ACT_REMOVE_AT) && $urandom_range(0, 3) != 0)
        pos = PosW'($urandom_range(0, list_len));
      else
        pos = PosW'($urandom);
      send_beat(act, pos, $urandom, pick_id(), pick_search());
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin : rx_side
    list_result_t got;
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, found_index_o, read_handle_o, read_id_o, item_count_o};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("beat %0d: unexpected result st=%0d idx=%0d h=%h id=%0d cnt=%0d",
                   result_beats, got.status, got.found_index, got.read_handle,
                   got.read_id, got.item_count);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax) begin
            $display("beat %0d: exp st=%0d idx=%0d h=%h id=%0d cnt=%0d",
                     result_beats, want.status, want.found_index, want.read_handle,
                     want.read_id, want.item_count);
            $display("beat %0d: got st=%0d idx=%0d h=%h id=%0d cnt=%0d",
                     result_beats, got.status, got.found_index, got.read_handle,
                     got.read_id, got.item_count);
          end
        end
      end
      result_beats++;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (rx_left < 4);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edge_values();
    test_fill_drain(4);
    test_random_mix(360);
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
